// ----- hw/rtl/icd_pkg.sv -----
// shared types and constants of the interrupt coalescing dispatcher
package icd_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned AGE_W = 21;
  localparam int unsigned FC_W  = 8;
  localparam int unsigned TOT_W = 24;
  localparam int unsigned TH_W  = 16;
  localparam int unsigned EL_W  = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [FC_W-1:0]  FC_MAX  = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [2:0] {
    CMD_COMPLETION = 3'd0,
    CMD_TICK       = 3'd1,
    CMD_FLUSH_ONE  = 3'd2,
    CMD_FLUSH_ALL  = 3'd3,
    CMD_MAP_QUEUE  = 3'd4,
    CMD_MASK       = 3'd5,
    CMD_ENABLE     = 3'd6,
    CMD_RSVD       = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PKT_TH  = 3'd0,
    REG_TMR_TH  = 3'd1,
    REG_AD_EN   = 3'd2,
    REG_SAMPLE  = 3'd3,
    REG_HIGH    = 3'd4,
    REG_LOW     = 3'd5,
    REG_MIN_TH  = 3'd6,
    REG_MAX_TH  = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_COMP      = 2'd0,
    OP_TICK      = 2'd1,
    OP_FLUSH_ONE = 2'd2,
    OP_FLUSH_ALL = 2'd3
  } op_e;

  typedef struct packed {
    logic             pend_v;
    logic [CNT_W-1:0] pend_cnt;
    logic             tmr_v;
    logic [AGE_W-1:0] age;
    logic             ad_v;
    logic [FC_W-1:0]  ad_fc;
    logic [TOT_W-1:0] ad_tot;
    logic [TH_W-1:0]  ad_th;
  } entry_t;

  typedef struct packed {
    logic [TH_W-1:0] pkt_th;
    logic [EL_W-1:0] tmr_th;
    logic            ad_en;
    logic [7:0]      sample;
    logic [15:0]     high;
    logic [15:0]     low;
    logic [TH_W-1:0] min_th;
    logic [TH_W-1:0] max_th;
  } cfg_t;

endpackage

// ----- hw/rtl/icd_entry_alu.sv -----
// shared read-modify-write unit for one vector entry
module icd_entry_alu (
  input  icd_pkg::op_e             op_i,
  input  icd_pkg::entry_t          entry_i,
  input  logic                     enabled_i,
  input  logic                     masked_i,
  input  icd_pkg::cfg_t            cfg_i,
  input  logic [icd_pkg::EL_W-1:0] el_i,
  output icd_pkg::entry_t          entry_o,
  output logic                     fire_o,
  output logic [icd_pkg::CNT_W-1:0] batch_o
);

  icd_pkg::entry_t        e;
  logic                   do_fire;
  logic [icd_pkg::TH_W-1:0] th;
  logic [icd_pkg::CNT_W-1:0] batch;
  logic [23:0]            hi_prod;
  logic [24:0]            lo_prod;
  logic [icd_pkg::AGE_W-1:0] el_ext;

  always_comb begin
    e       = entry_i;
    do_fire = 1'b0;
    th      = cfg_i.pkt_th;
    batch   = '0;
    fire_o  = 1'b0;
    hi_prod = '0;
    lo_prod = '0;
    el_ext  = icd_pkg::AGE_W'(el_i);
    case (op_i)
      icd_pkg::OP_COMP: begin
        if (!e.pend_v) begin
          e.pend_v   = 1'b1;
          e.pend_cnt = '0;
        end
        if (e.pend_cnt < icd_pkg::CNT_MAX) e.pend_cnt = e.pend_cnt + 1'b1;
        e.tmr_v = 1'b1;
        e.age   = '0;
        if (cfg_i.ad_en) begin
          if (e.ad_v) begin
            th = e.ad_th;
          end else begin
            e.ad_v   = 1'b1;
            e.ad_fc  = '0;
            e.ad_tot = '0;
            e.ad_th  = cfg_i.pkt_th;
          end
        end
        do_fire = (e.pend_cnt >= th);
      end
      icd_pkg::OP_TICK: begin
        if (e.pend_v && !e.tmr_v) begin
          e.tmr_v = 1'b1;
          e.age   = '0;
        end
        if (e.tmr_v) begin
          if (el_ext > icd_pkg::AGE_MAX - e.age) e.age = icd_pkg::AGE_MAX;
          else e.age = e.age + el_ext;
          do_fire = (e.age >= icd_pkg::AGE_W'(cfg_i.tmr_th));
        end
      end
      icd_pkg::OP_FLUSH_ONE: do_fire = 1'b1;
      icd_pkg::OP_FLUSH_ALL: do_fire = e.pend_v;
      default: do_fire = 1'b0;
    endcase

    if (do_fire) begin
      if (enabled_i && !masked_i) begin
        fire_o = 1'b1;
        if (e.pend_v) batch = e.pend_cnt;
        e.pend_v   = 1'b0;
        e.pend_cnt = '0;
        if (batch == '0) batch = icd_pkg::CNT_W'(1);
        if (cfg_i.ad_en) begin
          if (!e.ad_v) begin
            e.ad_v   = 1'b1;
            e.ad_fc  = '0;
            e.ad_tot = '0;
            e.ad_th  = cfg_i.pkt_th;
          end
          if (e.ad_fc < icd_pkg::FC_MAX) e.ad_fc = e.ad_fc + 1'b1;
          if (icd_pkg::TOT_W'(batch) > icd_pkg::TOT_MAX - e.ad_tot) e.ad_tot = icd_pkg::TOT_MAX;
          else e.ad_tot = e.ad_tot + icd_pkg::TOT_W'(batch);
          if (e.ad_fc >= cfg_i.sample) begin
            // avg >= high  <=>  total >= high*cnt ; avg <= low  <=>  total < (low+1)*cnt
            hi_prod = cfg_i.high * e.ad_fc;
            lo_prod = ({1'b0, cfg_i.low} + 17'd1) * e.ad_fc;
            if (e.ad_tot >= hi_prod && e.ad_th < cfg_i.max_th) e.ad_th = e.ad_th + 1'b1;
            else if ({1'b0, e.ad_tot} < lo_prod && e.ad_th > cfg_i.min_th)
              e.ad_th = e.ad_th - 1'b1;
            e.ad_fc  = '0;
            e.ad_tot = '0;
          end
        end
      end
      // timer entry goes away whether or not the fire was suppressed
      e.tmr_v = 1'b0;
      e.age   = '0;
    end
    entry_o = e;
    batch_o = batch;
  end

endmodule

// ----- hw/rtl/interrupt_coalescing_dispatcher_unit.sv -----
// interrupt coalescing dispatcher: sequencer, vector store and result output
// Command in: start_i with command/queue/vector/elapsed/flag fields, taken when busy_o
// is low. busy_o stays high until the command's last result has been produced.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i, ready
// whenever no command is in flight.
// Results: valid_o marks one result for one cycle; last_o flags the final one of a
// command. A command with no interrupt gives a single result with fired_o low.
// Walk: tick and flush-all walk all NUM_VECTORS entries (tick only when the timer
// threshold is nonzero and some vector is pending); the other commands touch at
// most one entry. The walk is paced by the single entry update unit, which does
// one read-modify-write per cycle.
// A fire is held until the next fire of the same command or the end of the command
// shows whether it is the last one; the receiver cannot stall, so results are never
// held off by the output side.
// Reset clears every vector, queue mapping and adaptive entry at once and loads
// the registers with their reset values; no clearing pass is needed.
module interrupt_coalescing_dispatcher_unit #(
  parameter int NUM_VECTORS = 16,
  parameter int NUM_QUEUES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [4:0]  queue_index_i,
  input  logic [3:0]  vector_index_i,
  input  logic [19:0] elapsed_us_i,
  input  logic        flag_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output logic        valid_o,
  output logic        fired_o,
  output logic [3:0]  fired_vector_o,
  output logic [15:0] irq_count_o,
  output logic        accepted_o,
  output logic        last_o
);

  localparam int VW = $clog2(NUM_VECTORS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_DONE
  } state_e;

  state_e             state_q;
  icd_pkg::cfg_t      cfg_q;
  icd_pkg::entry_t    ent_q [NUM_VECTORS];
  logic               en_q [NUM_VECTORS];
  logic               mask_q [NUM_VECTORS];
  logic [3:0]         map_vec_q [NUM_QUEUES];
  logic               map_v_q [NUM_QUEUES];

  logic [2:0]         cmd_q;
  logic [4:0]         q_q;
  logic [3:0]         vi_q;
  logic [19:0]        el_q;
  logic               flag_q;
  logic [VW-1:0]      idx_q;
  icd_pkg::op_e       op_q;
  logic               single_q;
  logic               acc_q;
  logic               held_v_q;
  logic [3:0]         held_vec_q;
  logic [15:0]        held_batch_q;

  icd_pkg::entry_t    alu_out;
  logic               alu_fire;
  logic [15:0]        alu_batch;
  logic               any_pend;
  logic [3:0]         mv;
  logic               mapv;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;

  always_comb begin
    any_pend = 1'b0;
    for (int i = 0; i < NUM_VECTORS; i++) any_pend |= ent_q[i].pend_v;
  end

  assign mv   = map_vec_q[q_q[QW-1:0]];
  assign mapv = (int'(q_q) < NUM_QUEUES) && map_v_q[q_q[QW-1:0]];

  icd_entry_alu u_alu (
    .op_i      (op_q),
    .entry_i   (ent_q[idx_q]),
    .enabled_i (en_q[idx_q]),
    .masked_i  (mask_q[idx_q]),
    .cfg_i     (cfg_q),
    .el_i      (el_q),
    .entry_o   (alu_out),
    .fire_o    (alu_fire),
    .batch_o   (alu_batch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_q        <= '{pkt_th: 16'd1, tmr_th: '0, ad_en: 1'b0, sample: 8'd8,
                        high: 16'd8, low: 16'd2, min_th: 16'd1, max_th: 16'd64};
      for (int i = 0; i < NUM_VECTORS; i++) begin
        ent_q[i]  <= '0;
        en_q[i]   <= 1'b0;
        mask_q[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        map_vec_q[i] <= '0;
        map_v_q[i]   <= 1'b0;
      end
      cmd_q        <= '0;
      q_q          <= '0;
      vi_q         <= '0;
      el_q         <= '0;
      flag_q       <= 1'b0;
      idx_q        <= '0;
      op_q         <= icd_pkg::OP_COMP;
      single_q     <= 1'b0;
      acc_q        <= 1'b0;
      held_v_q     <= 1'b0;
      held_vec_q   <= '0;
      held_batch_q <= '0;
      valid_o      <= 1'b0;
      fired_o      <= 1'b0;
      fired_vector_o <= '0;
      irq_count_o  <= '0;
      accepted_o   <= 1'b0;
      last_o       <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (icd_pkg::reg_e'(cfg_index_i))
          icd_pkg::REG_PKT_TH: cfg_q.pkt_th <= cfg_data_i[15:0];
          icd_pkg::REG_TMR_TH: cfg_q.tmr_th <= cfg_data_i;
          icd_pkg::REG_AD_EN: begin
            cfg_q.ad_en <= cfg_data_i[0];
            if (cfg_data_i[0]) begin
              for (int i = 0; i < NUM_VECTORS; i++) begin
                if (ent_q[i].ad_v) begin
                  ent_q[i].ad_fc  <= '0;
                  ent_q[i].ad_tot <= '0;
                  ent_q[i].ad_th  <= cfg_q.pkt_th;
                end
              end
            end
          end
          icd_pkg::REG_SAMPLE: cfg_q.sample <= cfg_data_i[7:0];
          icd_pkg::REG_HIGH:   cfg_q.high   <= cfg_data_i[15:0];
          icd_pkg::REG_LOW:    cfg_q.low    <= cfg_data_i[15:0];
          icd_pkg::REG_MIN_TH: cfg_q.min_th <= cfg_data_i[15:0];
          icd_pkg::REG_MAX_TH: cfg_q.max_th <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q    <= command_i;
            q_q      <= queue_index_i;
            vi_q     <= vector_index_i;
            el_q     <= elapsed_us_i;
            flag_q   <= flag_value_i;
            acc_q    <= 1'b0;
            held_v_q <= 1'b0;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_DONE;
          case (icd_pkg::cmd_e'(cmd_q))
            icd_pkg::CMD_COMPLETION: begin
              if (mapv && int'(mv) < NUM_VECTORS && en_q[VW'(mv)] && !mask_q[VW'(mv)]) begin
                acc_q    <= 1'b1;
                idx_q    <= VW'(mv);
                op_q     <= icd_pkg::OP_COMP;
                single_q <= 1'b1;
                state_q  <= S_WALK;
              end
            end
            icd_pkg::CMD_TICK: begin
              acc_q <= 1'b1;
              if (cfg_q.tmr_th != '0 && any_pend) begin
                idx_q    <= '0;
                op_q     <= icd_pkg::OP_TICK;
                single_q <= 1'b0;
                state_q  <= S_WALK;
              end
            end
            icd_pkg::CMD_FLUSH_ONE: begin
              if (int'(vi_q) < NUM_VECTORS) begin
                acc_q    <= 1'b1;
                idx_q    <= VW'(vi_q);
                op_q     <= icd_pkg::OP_FLUSH_ONE;
                single_q <= 1'b1;
                state_q  <= S_WALK;
              end
            end
            icd_pkg::CMD_FLUSH_ALL: begin
              acc_q    <= 1'b1;
              idx_q    <= '0;
              op_q     <= icd_pkg::OP_FLUSH_ALL;
              single_q <= 1'b0;
              state_q  <= S_WALK;
            end
            icd_pkg::CMD_MAP_QUEUE: begin
              if (int'(q_q) < NUM_QUEUES && int'(vi_q) < NUM_VECTORS) begin
                acc_q                  <= 1'b1;
                map_vec_q[q_q[QW-1:0]] <= vi_q;
                map_v_q[q_q[QW-1:0]]   <= 1'b1;
              end
            end
            icd_pkg::CMD_MASK: begin
              if (int'(vi_q) < NUM_VECTORS) begin
                acc_q              <= 1'b1;
                mask_q[VW'(vi_q)]  <= flag_q;
              end
            end
            icd_pkg::CMD_ENABLE: begin
              if (int'(vi_q) < NUM_VECTORS) begin
                acc_q            <= 1'b1;
                en_q[VW'(vi_q)]  <= flag_q;
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          ent_q[idx_q] <= alu_out;
          if (alu_fire) begin
            // a fire pushes the previous one out, since it is no longer the last
            if (held_v_q) begin
              valid_o        <= 1'b1;
              fired_o        <= 1'b1;
              fired_vector_o <= held_vec_q;
              irq_count_o    <= held_batch_q;
              accepted_o     <= acc_q;
              last_o         <= 1'b0;
            end
            held_v_q     <= 1'b1;
            held_vec_q   <= 4'(idx_q);
            held_batch_q <= alu_batch;
          end
          if (single_q || idx_q == VW'(NUM_VECTORS - 1)) state_q <= S_DONE;
          else idx_q <= idx_q + 1'b1;
        end
        S_DONE: begin
          valid_o        <= 1'b1;
          fired_o        <= held_v_q;
          fired_vector_o <= held_v_q ? held_vec_q : 4'd0;
          irq_count_o    <= held_v_q ? held_batch_q : 16'd0;
          accepted_o     <= acc_q;
          last_o         <= 1'b1;
          held_v_q       <= 1'b0;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("result right after a last result");
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o && fired_o)
    else $error("non-final result outside a command");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("command accepted without going busy");
`endif

endmodule
